FILE: rtl/vfra_pkg.sv
package vfra_pkg;

    // Fixed field widths of the request and response items.
    localparam int SIZE_W = 13;
    localparam int CNT_W  = 9;

    // Request kinds.
    typedef enum logic
    {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    // One header word: the skip flag and the stored payload size.
    typedef struct packed
    {
        logic              skip;
        logic [SIZE_W-1:0] size;
    } hdr_t;

endpackage

FILE: rtl/vfra_req_if.sv
interface vfra_req_if
    import vfra_pkg::*;
;
    logic              valid;
    logic              ready;
    action_t           action;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output action, output request_size, input ready);
    modport sink (input valid, input action, input request_size, output ready);
endinterface

FILE: rtl/vfra_rsp_if.sv
interface vfra_rsp_if
    import vfra_pkg::*;
#(
    parameter int OFS_W = 12
);
    logic              valid;
    logic              ready;
    logic              ok;
    logic [OFS_W-1:0]  payload_offset;
    logic [SIZE_W-1:0] popped_size;
    logic [CNT_W-1:0]  frames_held;

    modport source
    (
        output valid, output ok, output payload_offset, output popped_size,
        output frames_held, input ready
    );
    modport sink
    (
        input valid, input ok, input payload_offset, input popped_size,
        input frames_held, output ready
    );
endinterface

FILE: rtl/variable_frame_ring_allocator.sv
// Allocator for a power-of-two byte ring of variable-size frames, each a header of
// HEADER_BYTES followed by a payload rounded up to ALIGN_BYTES (a power of two). A push
// allocates a frame, wrapping to offset zero behind a skip marker when the frame does not
// fit before the ring end; a pop releases the oldest frame. One request is taken every
// clock cycle unless a response waits unread, and its response is registered; the rate
// is set by the header memory, whose single read port is kept pointed at the current read
// position so that a pop finds its header already registered. A wrapping push stores the
// frame size in the skip marker itself, so each push writes one header word and each pop
// reads one. The header memory needs no clearing after reset. The response channel must
// be instantiated with OFS_W equal to log2(RING_BYTES).
module variable_frame_ring_allocator
    import vfra_pkg::*;
#(
    parameter int RING_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 16,
    parameter int HEADER_BYTES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    vfra_req_if.sink          req,
    vfra_rsp_if.source        rsp
);

    // Lowest set bit among bits 7..0 of a value, used for the header slot granularity.
    function automatic int low_bit(input int v);
        int r;
        r = 0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = i;
            end
        end
        return r;
    endfunction

    localparam int PW    = $clog2(RING_BYTES) + 1;
    localparam int OW    = PW - 1;
    localparam int GSH   = low_bit(HEADER_BYTES | ALIGN_BYTES);
    localparam int DEPTH = RING_BYTES >> GSH;
    localparam int IW    = OW - GSH;
    localparam int AW    = (PW + 2 > 16) ? PW + 2 : 16;
    localparam bit CNT_EXACT = (RING_BYTES / HEADER_BYTES) < (1 << CNT_W);

    localparam logic [AW-1:0] RING_A = AW'(RING_BYTES);
    localparam logic [AW-1:0] HDR_A  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] ALN_M  = AW'(ALIGN_BYTES - 1);

    // Header plus payload rounded up to the alignment.
    function automatic logic [AW-1:0] frame_bytes(input logic [SIZE_W-1:0] size);
        logic [AW-1:0] rounded;
        rounded = (AW'(size) + ALN_M) & ~ALN_M;
        return HDR_A + rounded;
    endfunction

    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    wp_next;
    logic [PW-1:0]    rp_reg;
    logic [PW-1:0]    rp_next;
    logic [CNT_W-1:0] frame_total_reg;
    logic [CNT_W-1:0] frame_total_next;

    logic              rsp_valid_reg;
    logic              ok_reg;
    logic [OW-1:0]     payload_offset_reg;
    logic [SIZE_W-1:0] popped_size_reg;

    hdr_t             mem [DEPTH];
    hdr_t             hdr_reg;

    logic             fire;
    logic             is_pop;
    logic [PW-1:0]    used_raw;
    logic [AW-1:0]    used;
    logic [AW-1:0]    room;
    logic [OW-1:0]    wofs;
    logic [OW-1:0]    rofs;
    logic [AW-1:0]    to_end;
    logic [AW-1:0]    push_total;
    logic             push_here;
    logic             push_wrap;
    logic             push_ok;
    logic [AW-1:0]    push_step;
    logic [AW-1:0]    skip_step;
    logic [AW-1:0]    pop_step;
    logic             nonempty;
    logic             we;
    logic [IW-1:0]    waddr;
    hdr_t             wdata;
    logic [IW-1:0]    raddr;

    logic              ok_next;
    logic [OW-1:0]     payload_offset_next;
    logic [SIZE_W-1:0] popped_size_next;

    // Handshake: the output register frees up when its transfer completes.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_pop    = (req.action == ACT_POP);

    // Push sizing against the free space and the ring end.
    assign used_raw   = wp_reg - rp_reg;
    assign used       = (AW'(used_raw) > RING_A) ? RING_A : AW'(used_raw);
    assign room       = RING_A - used;
    assign wofs       = wp_reg[OW-1:0];
    assign rofs       = rp_reg[OW-1:0];
    assign to_end     = RING_A - AW'(wofs);
    assign push_total = frame_bytes(req.request_size);
    assign push_here  = (room >= push_total) && (to_end >= push_total);
    assign push_wrap  = (room >= push_total) && (to_end < push_total)
                        && (room >= push_total + to_end);
    assign push_ok    = push_here || push_wrap;
    assign push_step  = push_wrap ? to_end + push_total : push_total;

    // Pop: the prefetched header at the read position, skip marker jumps to zero.
    assign nonempty  = (wp_reg != rp_reg);
    assign skip_step = hdr_reg.skip ? RING_A - AW'(rofs) : '0;
    assign pop_step  = skip_step + frame_bytes(hdr_reg.size);

    // Header write for a successful push; a wrap marks the skip slot with the size.
    assign we         = fire && !is_pop && push_ok;
    assign waddr      = wofs[OW-1:GSH];
    assign wdata.skip = push_wrap;
    assign wdata.size = req.request_size;

    // Next state and response.
    always_comb
    begin
        wp_next             = wp_reg;
        rp_next             = rp_reg;
        frame_total_next    = frame_total_reg;
        ok_next             = 1'b0;
        payload_offset_next = '0;
        popped_size_next    = '0;
        if (fire)
        begin
            if (!is_pop)
            begin
                if (push_ok)
                begin
                    wp_next             = wp_reg + push_step[PW-1:0];
                    frame_total_next    = frame_total_reg + CNT_W'(1);
                    ok_next             = 1'b1;
                    payload_offset_next = push_wrap ? HDR_A[OW-1:0]
                                                    : OW'(AW'(wofs) + HDR_A);
                end
            end
            else if (nonempty)
            begin
                rp_next             = rp_reg + pop_step[PW-1:0];
                frame_total_next    = frame_total_reg - CNT_W'(1);
                ok_next             = 1'b1;
                payload_offset_next = hdr_reg.skip ? HDR_A[OW-1:0]
                                                   : OW'(AW'(rofs) + HDR_A);
                popped_size_next    = hdr_reg.size;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            frame_total_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            frame_total_reg <= frame_total_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg             <= ok_next;
            payload_offset_reg <= payload_offset_next;
            popped_size_reg    <= popped_size_next;
        end
    end

    // Header memory; the read port follows the next read position, with write bypass.
    assign raddr = rp_next[OW-1:GSH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            hdr_reg <= wdata;
        end
        else
        begin
            hdr_reg <= mem[raddr];
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.payload_offset = payload_offset_reg;
    assign rsp.popped_size    = popped_size_reg;
    assign rsp.frames_held    = frame_total_reg;

    // The bytes in use never exceed the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_raw <= PW'(RING_BYTES))
        else $error("ring occupancy exceeds ring size");

    // With an exact count, an empty count means equal pointers.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_EXACT |-> ((frame_total_reg == '0) == (wp_reg == rp_reg)))
        else $error("frame count disagrees with pointers");

    // A pop on a non-empty ring releases exactly one frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_pop && nonempty)
        |=> (frame_total_reg == $past(frame_total_reg) - CNT_W'(1)))
        else $error("pop did not release one frame");

endmodule
